FILE: rtl/core/mps_pkg.sv
`default_nettype none

package mps_pkg;

  // grid limits
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int CAPACITY = MAX_ROWS * MAX_COLS;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SP_W   = $clog2(CAPACITY + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DIM_W  = 7;
  localparam int PROD_W = ROW_W + DIM_W;
  localparam int DIR_W  = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  // expansion order
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  localparam logic [DIM_W-1:0] DIM_MIN = 7'd3;

  typedef logic [DIM_W-1:0] dim_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIR_W-1:0] dir;
  } stack_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;
  } grid_port_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    stack_entry_t      wdata;
    logic [ADDR_W-1:0] raddr;
  } stack_port_t;

  typedef struct packed {
    logic valid;
    logic found;
  } result_t;

  typedef struct packed {
    logic            searching;
    logic [SP_W-1:0] sp;
  } status_t;

  // saturate a dimension into its legal range
  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // row-major address of cell (r, c)
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c,
                                                  input dim_t cols);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(r) * PROD_W'(cols);
    return ADDR_W'(prod + PROD_W'(c));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mps_ram.sv
`default_nettype none

module mps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/mps_ctrl.sv
`default_nettype none

module mps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 is_wall,
  input  wire logic                 last_cell,
  output logic                      in_stall,
  input  wire mps_pkg::dim_t        row_count,
  input  wire mps_pkg::dim_t        col_count,
  input  wire logic                 out_free,
  output mps_pkg::grid_port_t       grid_port,
  input  wire logic                 grid_rdata,
  output mps_pkg::stack_port_t      stack_port,
  input  wire mps_pkg::stack_entry_t stack_rdata,
  output mps_pkg::result_t          res,
  output mps_pkg::status_t          stat
);

  import mps_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state, state_next;
  logic [SP_W-1:0]   load_pos, load_pos_next;
  logic [SP_W-1:0]   sp, sp_next;
  dim_t              rows, rows_next;
  dim_t              cols, cols_next;
  stack_entry_t      top, top_next;
  logic              top_done, top_done_next;
  logic [ROW_W-1:0]  nb_row, nb_row_next;
  logic [COL_W-1:0]  nb_col, nb_col_next;
  logic [ADDR_W-1:0] nb_addr, nb_addr_next;
  logic              nb_goal, nb_goal_next;
  logic              found, found_next;

  logic              accept;
  logic              in_grid;
  logic [ROW_W-1:0]  nr;
  logic [COL_W-1:0]  nc;
  dim_t              row_ext, col_ext;
  logic [ADDR_W-1:0] probe_addr;
  logic              goal_hit;
  logic              pop_now;

  assign in_stall = (state != S_LOAD);
  assign accept   = in_valid && !in_stall;

  assign stat.searching = (state != S_LOAD);
  assign stat.sp        = sp;

  // neighbor of the top cell in its current direction
  always_comb begin
    row_ext = DIM_W'(top.row);
    col_ext = DIM_W'(top.col);
    nr      = top.row;
    nc      = top.col;
    case (top.dir)
      DIR_DOWN: begin
        in_grid = (row_ext + 1'b1) < rows;
        nr      = top.row + 1'b1;
      end
      DIR_RIGHT: begin
        in_grid = (col_ext + 1'b1) < cols;
        nc      = top.col + 1'b1;
      end
      DIR_UP: begin
        in_grid = (top.row != '0);
        nr      = top.row - 1'b1;
      end
      default: begin
        in_grid = (top.col != '0);
        nc      = top.col - 1'b1;
      end
    endcase
  end

  assign probe_addr = cell_addr(nr, nc, cols);
  assign goal_hit   = (DIM_W'(nr) == rows - 7'd2) && (DIM_W'(nc) == cols - 7'd2);

  // sequencer: load cells, then walk the stack one probe at a time
  always_comb begin
    state_next    = state;
    load_pos_next = load_pos;
    sp_next       = sp;
    rows_next     = rows;
    cols_next     = cols;
    top_next      = top;
    top_done_next = top_done;
    nb_row_next   = nb_row;
    nb_col_next   = nb_col;
    nb_addr_next  = nb_addr;
    nb_goal_next  = nb_goal;
    found_next    = found;
    pop_now       = 1'b0;

    grid_port        = '0;
    grid_port.raddr  = probe_addr;
    stack_port       = '0;
    res.valid        = 1'b0;
    res.found        = found;

    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (load_pos < SP_W'(CAPACITY)) begin
            grid_port.we    = 1'b1;
            grid_port.waddr = load_pos[ADDR_W-1:0];
            grid_port.wdata = is_wall;
            load_pos_next   = load_pos + 1'b1;
          end
          if (last_cell) begin
            rows_next     = clamp_dim(row_count, DIM_W'(MAX_ROWS));
            cols_next     = clamp_dim(col_count, DIM_W'(MAX_COLS));
            load_pos_next = '0;
            state_next    = S_INIT;
          end
        end
      end

      S_INIT: begin
        if (rows == DIM_MIN && cols == DIM_MIN) begin
          // start cell is the goal
          found_next = 1'b1;
          state_next = S_DONE;
        end else begin
          grid_port.we    = 1'b1;
          grid_port.waddr = cell_addr(ROW_W'(1), COL_W'(1), cols);
          grid_port.wdata = 1'b1;
          top_next.row    = ROW_W'(1);
          top_next.col    = COL_W'(1);
          top_next.dir    = DIR_DOWN;
          sp_next         = SP_W'(1);
          state_next      = S_STEP;
        end
      end

      S_STEP: begin
        nb_row_next   = nr;
        nb_col_next   = nc;
        nb_addr_next  = probe_addr;
        nb_goal_next  = goal_hit;
        top_done_next = (top.dir == DIR_LEFT);
        if (top.dir != DIR_LEFT) begin
          top_next.dir = top.dir + 1'b1;
        end
        if (in_grid) begin
          state_next = S_CHECK;
        end else if (top.dir == DIR_LEFT) begin
          pop_now = 1'b1;
        end
      end

      S_CHECK: begin
        if (grid_rdata) begin
          if (top_done) begin
            pop_now = 1'b1;
          end else begin
            state_next = S_STEP;
          end
        end else if (nb_goal) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else begin
          // mark the cell and descend into it
          grid_port.we    = 1'b1;
          grid_port.waddr = nb_addr;
          grid_port.wdata = 1'b1;
          state_next      = S_STEP;
          if (top_done) begin
            top_next.row = nb_row;
            top_next.col = nb_col;
            top_next.dir = DIR_DOWN;
          end else if (sp < SP_W'(CAPACITY)) begin
            stack_port.we    = 1'b1;
            stack_port.waddr = ADDR_W'(sp - 1'b1);
            stack_port.wdata = top;
            top_next.row     = nb_row;
            top_next.col     = nb_col;
            top_next.dir     = DIR_DOWN;
            sp_next          = sp + 1'b1;
          end
        end
      end

      S_POP: begin
        top_next   = stack_rdata;
        state_next = S_STEP;
      end

      S_DONE: begin
        if (out_free) begin
          res.valid  = 1'b1;
          sp_next    = '0;
          state_next = S_LOAD;
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase

    // drop the finished top; the stack below it lives in memory
    if (pop_now) begin
      sp_next = sp - 1'b1;
      if (sp == SP_W'(1)) begin
        found_next = 1'b0;
        state_next = S_DONE;
      end else begin
        stack_port.raddr = ADDR_W'(sp - 2'd2);
        state_next       = S_POP;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      load_pos <= '0;
      sp       <= '0;
      found    <= 1'b0;
    end else begin
      state    <= state_next;
      load_pos <= load_pos_next;
      sp       <= sp_next;
      found    <= found_next;
    end
  end

  // search datapath
  always_ff @(posedge clk) begin
    rows     <= rows_next;
    cols     <= cols_next;
    top      <= top_next;
    top_done <= top_done_next;
    nb_row   <= nb_row_next;
    nb_col   <= nb_col_next;
    nb_addr  <= nb_addr_next;
    nb_goal  <= nb_goal_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/maze_path_search_core.sv
// Loading: one grid cell per cycle, in_stall stays low while cells stream in.
// Search: starts the cycle after the last cell; a probe inside the grid is an
// issue (S_STEP) and a grid read (S_CHECK), one outside it only the issue, a
// backtrack one stack read (S_POP); then the result enters the result register.
// Reset (rst, synchronous): control cleared, row_count and col_count set to 64;
// the grid and stack memories are not cleared and take no clearing pass.
`default_nettype none

module maze_path_search_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             is_wall,
  input  wire logic                             last_cell,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  exit_found,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mps_pkg::DIM_W-1:0]        cfg_data
);

  import mps_pkg::*;

  dim_t         row_count;
  dim_t         col_count;
  logic         out_free;
  grid_port_t   grid_port;
  logic         grid_rdata;
  stack_port_t  stack_port;
  stack_entry_t stack_rdata;
  result_t      res;
  status_t      stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= DIM_W'(64);
      col_count <= DIM_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  mps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .is_wall     (is_wall),
    .last_cell   (last_cell),
    .in_stall    (in_stall),
    .row_count   (row_count),
    .col_count   (col_count),
    .out_free    (out_free),
    .grid_port   (grid_port),
    .grid_rdata  (grid_rdata),
    .stack_port  (stack_port),
    .stack_rdata (stack_rdata),
    .res         (res),
    .stat        (stat)
  );

  mps_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_port.we),
    .waddr (grid_port.waddr),
    .wdata (grid_port.wdata),
    .raddr (grid_port.raddr),
    .rdata (grid_rdata)
  );

  mps_ram #(
    .WIDTH ($bits(stack_entry_t)),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_port.we),
    .waddr (stack_port.waddr),
    .wdata (stack_port.wdata),
    .raddr (stack_port.raddr),
    .rdata (stack_rdata)
  );

  assign out_free = !out_valid || !out_stall;

  // output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      exit_found <= res.found;
    end
  end

  // the search owns the grid right after the last cell
  a_last_starts_search: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_cell) |=> in_stall)
    else $error("input not stalled after last cell");

  // results come only out of the search phase
  a_result_in_search: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (stat.searching && out_free))
    else $error("result issued outside search or into a full register");

  // the stack never grows past the grid capacity
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    stat.sp <= SP_W'(CAPACITY))
    else $error("stack pointer beyond capacity");

  // a new result always lands in the output register
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> (out_valid && exit_found == $past(res.found)))
    else $error("result lost on its way to the output");

endmodule

`default_nettype wire
